@@ design/longest_prefix_match_table_defines.svh @@
// assertion macros for the route table
`ifndef LONGEST_PREFIX_MATCH_TABLE_DEFINES_SVH
`define LONGEST_PREFIX_MATCH_TABLE_DEFINES_SVH

`ifndef SYNTHESIS

// property that holds on every clock edge out of reset
`define LPM_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("route table check failed");

// antecedent implies consequent on the next edge
`define LPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("route table sequencing check failed");

`else

`define LPM_ASSERT(label, clk, rst_n, prop)
`define LPM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ design/lpm_pkg.sv @@
package lpm_pkg;

  localparam int unsigned AddrW    = 32;
  localparam int unsigned RouteW   = 16;
  localparam int unsigned LenW     = 6;
  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 24;

  // request kinds carried in tuser
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FINISH
  } lpm_state_e;

  // best-so-far record handed from cell to cell
  typedef struct packed {
    logic              found;
    logic [LenW-1:0]   len;
    logic [RouteW-1:0] route;
    logic              dup_hit;
    logic              free_hit;
  } lpm_acc_t;

  // table write broadcast to every cell
  typedef struct packed {
    logic              en;
    logic [AddrW-1:0]  prefix;
    logic [AddrW-1:0]  netmask;
    logic [LenW-1:0]   plen;
    logic [RouteW-1:0] route;
  } lpm_wr_t;

  // result word, lowest bit is found
  typedef struct packed {
    logic              table_full;
    logic [LenW-1:0]   matched_length;
    logic [RouteW-1:0] matched_route;
    logic              found;
  } lpm_res_t;

  // prefix length of a contiguous netmask, zero when it can never match
  function automatic logic [LenW-1:0] mask_len(input logic [AddrW-1:0] m);
    logic [AddrW-1:0] inv;
    logic             contig;
    inv    = ~m;
    contig = ((inv & (inv + AddrW'(1))) == '0) && (m != '0);
    return contig ? LenW'($countones(m)) : '0;
  endfunction

endpackage

@@ design/lpm_cell.sv @@
module lpm_cell
  import lpm_pkg::*;
#(
  parameter int unsigned IdxW    = 6,
  parameter int unsigned CellIdx = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lpm_wr_t           wr_i,
  input  logic [IdxW-1:0]   wr_idx_i,
  input  logic [AddrW-1:0]  addr_i,
  input  lpm_acc_t          acc_i,
  input  logic [IdxW-1:0]   dup_idx_i,
  input  logic [IdxW-1:0]   free_idx_i,
  output lpm_acc_t          acc_o,
  output logic [IdxW-1:0]   dup_idx_o,
  output logic [IdxW-1:0]   free_idx_o
);

  logic              valid_q;
  logic [AddrW-1:0]  prefix_q;
  logic [AddrW-1:0]  netmask_q;
  logic [LenW-1:0]   plen_q;
  logic [RouteW-1:0] route_q;

  lpm_acc_t          acc_d, acc_q;
  logic [IdxW-1:0]   dup_idx_d, dup_idx_q;
  logic [IdxW-1:0]   free_idx_d, free_idx_q;

  logic              sel;
  logic              dup_match;
  logic              lpm_match;

  assign sel = wr_i.en && (wr_idx_i == IdxW'(CellIdx));

  // entry occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (sel) begin
      valid_q <= 1'b1;
    end
  end

  // entry contents
  always_ff @(posedge clk_i) begin
    if (sel) begin
      prefix_q  <= wr_i.prefix;
      netmask_q <= wr_i.netmask;
      plen_q    <= wr_i.plen;
      route_q   <= wr_i.route;
    end
  end

  // compare this entry against the request
  assign dup_match = valid_q && (prefix_q == addr_i);
  assign lpm_match = valid_q && (plen_q != '0) && (prefix_q == (addr_i & netmask_q))
                     && (plen_q > acc_i.len);

  // fold this entry into the running record
  always_comb begin
    acc_d      = acc_i;
    dup_idx_d  = dup_idx_i;
    free_idx_d = free_idx_i;
    if (lpm_match) begin
      acc_d.found = 1'b1;
      acc_d.len   = plen_q;
      acc_d.route = route_q;
    end
    if (dup_match) begin
      acc_d.dup_hit = 1'b1;
      dup_idx_d     = IdxW'(CellIdx);
    end
    if (!valid_q && !acc_i.free_hit) begin
      acc_d.free_hit = 1'b1;
      free_idx_d     = IdxW'(CellIdx);
    end
  end

  // hand the record on to the next cell
  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    dup_idx_q  <= dup_idx_d;
    free_idx_q <= free_idx_d;
  end

  assign acc_o      = acc_q;
  assign dup_idx_o  = dup_idx_q;
  assign free_idx_o = free_idx_q;

endmodule

@@ design/longest_prefix_match_table.sv @@
// IPv4 route table with longest-prefix lookup. Each request on the slave
// stream is either an insert (tuser 0) or a lookup (tuser 1) and yields one
// result word on the master stream. The table is a chain of TABLE_ENTRIES
// cells, one route each; a request is held while a best-match record walks
// the chain one cell per clock, so the next request is taken only after the
// sweep of the chain, a finish state that commits the insert and loads the
// result, and the return to the idle state in which it is taken. A finished
// result waits in its own output register, so the next request can be taken
// while it is still pending; the commit of that next request waits for as
// long as the earlier result is still held. Inserts reuse the entry already
// holding the same prefix, otherwise the lowest free entry; on a full table
// the insert is dropped and table_full is set. A lookup reports the longest
// contiguous prefix of /1 to /32 whose entry matches the address; /0 and
// non-contiguous netmasks never match. The table is empty after reset.
`include "longest_prefix_match_table_defines.svh"

module longest_prefix_match_table
  import lpm_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // address [31:0], mask_in [63:32], route_index [79:64]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // req_type [0]
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // found [0], matched_route [16:1], matched_length [22:17], table_full [23]
  output logic [OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  lpm_state_e        state_q, state_d;
  logic [IdxW-1:0]   cnt_q;

  logic              req_type_q;
  logic [AddrW-1:0]  addr_q;
  logic [AddrW-1:0]  mask_q;
  logic [RouteW-1:0] route_q;

  lpm_res_t          res_q, res_d;
  logic              out_valid_q;

  logic              accept;
  logic              advance;
  logic              sweep_done;
  lpm_wr_t           wr;
  logic [IdxW-1:0]   wr_idx;

  lpm_acc_t          acc_w      [TABLE_ENTRIES+1];
  logic [IdxW-1:0]   dup_idx_w  [TABLE_ENTRIES+1];
  logic [IdxW-1:0]   free_idx_w [TABLE_ENTRIES+1];

  lpm_acc_t          acc_end;
  logic              is_insert;

  assign accept     = s_axis_tvalid && s_axis_tready;
  assign sweep_done = (cnt_q == IdxW'(TABLE_ENTRIES - 1));
  assign acc_end    = acc_w[TABLE_ENTRIES];
  assign is_insert  = (req_type_q == REQ_INSERT);

  // request register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_type_q <= s_axis_tuser;
      addr_q     <= s_axis_tdata[31:0];
      mask_q     <= s_axis_tdata[63:32];
      route_q    <= s_axis_tdata[79:64];
    end
  end

  // state and sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        cnt_q <= '0;
      end else if (state_q == ST_SWEEP) begin
        cnt_q <= cnt_q + IdxW'(1);
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (sweep_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs: handshake, table write and result
  always_comb begin
    s_axis_tready = 1'b0;
    advance       = 1'b0;
    unique case (state_q)
      ST_IDLE:   s_axis_tready = 1'b1;
      ST_SWEEP:  advance = 1'b0;
      ST_FINISH: advance = !out_valid_q || m_axis_tready;
      default:   s_axis_tready = 1'b0;
    endcase

    wr.en      = advance && is_insert && (acc_end.dup_hit || acc_end.free_hit);
    wr.prefix  = addr_q;
    wr.netmask = mask_q;
    wr.plen    = mask_len(mask_q);
    wr.route   = route_q;
    wr_idx     = acc_end.dup_hit ? dup_idx_w[TABLE_ENTRIES] : free_idx_w[TABLE_ENTRIES];

    res_d.found          = !is_insert && acc_end.found;
    res_d.matched_route  = res_d.found ? acc_end.route : '0;
    res_d.matched_length = res_d.found ? acc_end.len : '0;
    res_d.table_full     = is_insert && !acc_end.dup_hit && !acc_end.free_hit;
  end

  // chain of route cells
  assign acc_w[0]      = '0;
  assign dup_idx_w[0]  = '0;
  assign free_idx_w[0] = '0;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    lpm_cell #(
      .IdxW    (IdxW),
      .CellIdx (i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .wr_i       (wr),
      .wr_idx_i   (wr_idx),
      .addr_i     (addr_q),
      .acc_i      (acc_w[i]),
      .dup_idx_i  (dup_idx_w[i]),
      .free_idx_i (free_idx_w[i]),
      .acc_o      (acc_w[i+1]),
      .dup_idx_o  (dup_idx_w[i+1]),
      .free_idx_o (free_idx_w[i+1])
    );
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res_q;

  // checks
  `LPM_ASSERT(a_found_not_full, clk_i, rst_ni, !(out_valid_q && res_q.found && res_q.table_full))
  `LPM_ASSERT(a_len_iff_found, clk_i, rst_ni, !out_valid_q || res_q.found == |res_q.matched_length)
  `LPM_ASSERT_NEXT(a_accept_sweeps, clk_i, rst_ni, accept, state_q == ST_SWEEP)

endmodule
